FILE: rtl/small_matrix_arith_engine_unit_macros.svh
// Assertion macros shared by the matrix engine RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SMALL_MATRIX_ARITH_ENGINE_UNIT_MACROS_SVH
`define SMALL_MATRIX_ARITH_ENGINE_UNIT_MACROS_SVH

// expression must never hold outside reset
`define SMAE_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("smae: forbidden condition seen");

// consequent must hold in the same cycle as the antecedent
`define SMAE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smae: implication failed");

// consequent must hold in the cycle after the antecedent
`define SMAE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smae: next-cycle implication failed");

`endif

FILE: rtl/smae_pkg.sv
// Types, codes and constants for the small matrix arithmetic engine.
// No dependencies; used by every module of the engine but smae_ram.
`timescale 1ns / 1ps
package smae_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int MAX_DIM_DEF = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int CSR_IDX_W   = 3;

   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_START  = 2'd2;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_SUB   = 2'd1;
   localparam logic [1:0] MODE_MUL   = 2'd2;
   localparam logic [1:0] MODE_SCALE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 3'd4;

   typedef enum logic [1:0] {
      KIND_LOAD_A,
      KIND_LOAD_B,
      KIND_START
   } smae_kind_type;

   typedef struct packed {
      logic [1:0]                   op;
      logic [2:0]                   row;
      logic [2:0]                   col;
      logic signed [DATA_WIDTH-1:0] value;
   } smae_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_value;
      logic [2:0]                   result_row;
      logic [2:0]                   result_col;
      logic                         last;
   } smae_rsp_type;

   typedef struct packed {
      smae_kind_type         kind;
      logic [2:0]            row;
      logic [2:0]            col;
      logic [DATA_WIDTH-1:0] value;
   } smae_entry_type;

   typedef struct packed {
      logic [1:0]                   mode;
      logic [3:0]                   rows_a;
      logic [3:0]                   cols_a;
      logic [3:0]                   cols_b;
      logic signed [DATA_WIDTH-1:0] scale_factor;
   } smae_cfg_type;

   localparam smae_cfg_type CFG_RESET = '{
      mode:         MODE_ADD,
      rows_a:       4'd4,
      cols_a:       4'd4,
      cols_b:       4'd4,
      scale_factor: 32'sd1
   };

endpackage

FILE: rtl/smae_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module smae_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/smae_front.sv
// Front end: accepts request beats, drops ignored ones, tags the rest.
// Depends on smae_pkg.
`timescale 1ns / 1ps
module smae_front #(
   parameter int MAX_DIM = smae_pkg::MAX_DIM_DEF
) (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  smae_pkg::smae_req_type   req_data,
   input  logic                     q_full,
   output logic                     q_push,
   output smae_pkg::smae_entry_type q_entry
);
   import smae_pkg::*;

   logic in_range;
   logic keep;

   assign in_range = (int'(req_data.row) < MAX_DIM) && (int'(req_data.col) < MAX_DIM);

   always_comb begin
      keep          = 1'b0;
      q_entry.kind  = KIND_START;
      q_entry.row   = req_data.row;
      q_entry.col   = req_data.col;
      q_entry.value = req_data.value;
      case (req_data.op)
         OP_LOAD_A: begin
            keep         = in_range;
            q_entry.kind = KIND_LOAD_A;
         end
         OP_LOAD_B: begin
            keep         = in_range;
            q_entry.kind = KIND_LOAD_B;
         end
         OP_START: begin
            keep         = 1'b1;
            q_entry.kind = KIND_START;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full && keep;

endmodule

FILE: rtl/smae_fifo.sv
// Short queue of classified beats between front and back ends.
// Depends on smae_pkg.
`timescale 1ns / 1ps
module smae_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  smae_pkg::smae_entry_type push_entry,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output smae_pkg::smae_entry_type head_entry
);
   import smae_pkg::*;

   smae_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

endmodule

FILE: rtl/smae_back.sv
// Back end: writes the stores and runs add, subtract, product and scale.
// Depends on smae_pkg, smae_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "small_matrix_arith_engine_unit_macros.svh"
module smae_back #(
   parameter int MAX_DIM = smae_pkg::MAX_DIM_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  smae_pkg::smae_cfg_type   cfg,
   input  logic                     q_valid,
   input  smae_pkg::smae_entry_type q_entry,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output smae_pkg::smae_rsp_type   rsp_data
);
   import smae_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } smae_state_type;

   typedef struct packed {
      logic       first;
      logic       last_k;
      logic       last_elem;
      logic [2:0] row;
      logic [2:0] col;
   } smae_tag_type;

   function automatic logic [IW-1:0] last_idx(input logic [3:0] d);
      logic [IW-1:0] r;
      if (d == 4'd0) begin
         r = '0;
      end else if (int'(d) > MAX_DIM) begin
         r = IW'(MAX_DIM - 1);
      end else begin
         r = IW'(int'(d) - 1);
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] addr_of(input int r, input int c);
      return AW'(r * MAX_DIM + c);
   endfunction

   smae_state_type        state_ff, state_in;
   logic [IW-1:0]         i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IW-1:0]         i_last, j_last, k_last;
   logic                  mode_mul, k_done, issue, adv;
   logic                  a_we, b_we;
   logic [AW-1:0]         wr_addr, a_rd_addr, b_rd_addr;
   logic [DATA_WIDTH-1:0] a_rd_data, b_rd_data, mul_op, product, term_in, acc_sum;
   smae_tag_type          tag_in;
   logic                  s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   smae_tag_type          s1_tag_ff, s2_tag_ff;
   logic [DATA_WIDTH-1:0] term_ff, acc_ff;
   smae_rsp_type          rsp_ff, rsp_in;

   assign mode_mul = (cfg.mode == MODE_MUL);
   assign i_last   = last_idx(cfg.rows_a);
   assign k_last   = last_idx(cfg.cols_a);
   assign j_last   = mode_mul ? last_idx(cfg.cols_b) : k_last;
   assign k_done   = !mode_mul || (k_ff == k_last);
   assign adv      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      q_pop    = 1'b0;
      a_we     = 1'b0;
      b_we     = 1'b0;
      issue    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_entry.kind)
                  KIND_LOAD_A: a_we = 1'b1;
                  KIND_LOAD_B: b_we = 1'b1;
                  KIND_START: begin
                     state_in = ST_RUN;
                     i_in     = '0;
                     j_in     = '0;
                     k_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (adv) begin
               issue = 1'b1;
               if (k_done) begin
                  k_in = '0;
                  if (j_ff == j_last) begin
                     j_in = '0;
                     if (i_ff == i_last) begin
                        state_in = ST_IDLE;
                     end else begin
                        i_in = i_ff + 1'b1;
                     end
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign wr_addr   = addr_of(int'(q_entry.row), int'(q_entry.col));
   assign a_rd_addr = addr_of(int'(i_ff), mode_mul ? int'(k_ff) : int'(j_ff));
   assign b_rd_addr = addr_of(mode_mul ? int'(k_ff) : int'(i_ff), int'(j_ff));

   smae_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (q_entry.value),
      .rd_en   (adv),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   smae_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (q_entry.value),
      .rd_en   (adv),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   always_comb begin
      tag_in.first     = (k_ff == '0);
      tag_in.last_k    = k_done;
      tag_in.last_elem = (i_ff == i_last) && (j_ff == j_last);
      tag_in.row       = 3'(i_ff);
      tag_in.col       = 3'(j_ff);
   end

   assign mul_op  = (cfg.mode == MODE_SCALE) ? cfg.scale_factor : b_rd_data;
   assign product = a_rd_data * mul_op;

   always_comb begin
      case (cfg.mode)
         MODE_ADD: term_in = a_rd_data + b_rd_data;
         MODE_SUB: term_in = a_rd_data - b_rd_data;
         default:  term_in = product;
      endcase
   end

   assign acc_sum = s2_tag_ff.first ? term_ff : acc_ff + term_ff;

   always_comb begin
      rsp_in.result_value = acc_sum;
      rsp_in.result_row   = s2_tag_ff.row;
      rsp_in.result_col   = s2_tag_ff.col;
      rsp_in.last         = s2_tag_ff.last_elem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         if (adv) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff && s2_tag_ff.last_k;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff <= tag_in;
         s2_tag_ff <= s1_tag_ff;
         term_ff   <= term_in;
         if (s2_valid_ff) begin
            acc_ff <= acc_sum;
            if (s2_tag_ff.last_k) begin
               rsp_ff <= rsp_in;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SMAE_ASSERT_NEVER(a_dual_store_write, clock, reset, a_we && b_we)
   `SMAE_ASSERT_IMPLY(a_no_load_in_run, clock, reset, state_ff == ST_RUN, !a_we && !b_we && !q_pop)
   `SMAE_ASSERT_NEXT(a_start_enters_run, clock, reset, (state_ff == ST_IDLE) && q_valid && (q_entry.kind == KIND_START), state_ff == ST_RUN)
   `SMAE_ASSERT_NEXT(a_result_lands, clock, reset, adv && s2_valid_ff && s2_tag_ff.last_k, rsp_valid_ff)

endmodule

FILE: rtl/small_matrix_arith_engine_unit.sv
// Load beats: one per cycle while the queue has room, written once the idle back end pops them.
// Start beat: results pass the store read, term and result registers; while the output is
// not stalled, one element per cycle for add, subtract and scale, and for the product one
// multiply-accumulate a cycle over the single read port of each store, cols_a per element.
// Synchronous reset clears control and sets mode 0, dimensions 4, scale 1; stores stay unset.
`timescale 1ns / 1ps
module small_matrix_arith_engine_unit #(
   parameter int MAX_DIM = smae_pkg::MAX_DIM_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  smae_pkg::smae_req_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output smae_pkg::smae_rsp_type                 rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [smae_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [smae_pkg::DATA_WIDTH-1:0]        csr_data
);
   import smae_pkg::*;

   smae_cfg_type   cfg_ff;
   logic           q_full, q_push, q_pop, q_valid;
   smae_entry_type push_entry, head_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MODE:   cfg_ff.mode         <= csr_data[1:0];
            CSR_ROWS_A: cfg_ff.rows_a       <= csr_data[3:0];
            CSR_COLS_A: cfg_ff.cols_a       <= csr_data[3:0];
            CSR_COLS_B: cfg_ff.cols_b       <= csr_data[3:0];
            CSR_SCALE:  cfg_ff.scale_factor <= csr_data;
            default: ;
         endcase
      end
   end

   smae_front #(.MAX_DIM(MAX_DIM)) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   smae_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   smae_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_entry   (head_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: bench/tb.sv
// Self-checking bench for the small matrix arithmetic engine: loads, starts, register writes.
// Depends on smae_pkg and small_matrix_arith_engine_unit; predicts every result element.
`timescale 1ns / 1ps
module tb;
   import smae_pkg::*;

   localparam int GRID = MAX_DIM_DEF;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   smae_req_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   smae_rsp_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   small_matrix_arith_engine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // shadow of the engine: registers and both element stores
   smae_cfg_type  shadow_cfg = CFG_RESET;
   logic [31:0]   mat_a [GRID*GRID];
   logic [31:0]   mat_b [GRID*GRID];
   smae_rsp_type  expected_elems [$];

   // generation side: queued beats and which entries they will have written
   smae_req_type  pend_reqs [$];
   bit            filled_a [GRID*GRID];
   bit            filled_b [GRID*GRID];

   int gen_items = 0;
   int taken_items = 0;
   int load_beats = 0;
   int start_beats = 0;
   int checked_elems = 0;
   int settings_run = 0;
   int fail_count = 0;
   int send_idle_pct = 26;
   int recv_idle_pct = 86;

   function automatic int clamp_dim(logic [3:0] d);
      if (d == 4'd0) return 1;
      if (d > GRID) return GRID;
      return int'(d);
   endfunction

   function automatic void shadow_reg_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
         CSR_MODE:   shadow_cfg.mode = data[1:0];
         CSR_ROWS_A: shadow_cfg.rows_a = data[3:0];
         CSR_COLS_A: shadow_cfg.cols_a = data[3:0];
         CSR_COLS_B: shadow_cfg.cols_b = data[3:0];
         CSR_SCALE:  shadow_cfg.scale_factor = data;
         default: ;
      endcase
   endfunction

   function automatic void expand_result();
      int nr;
      int nk;
      int nc;
      logic [31:0] acc;
      smae_rsp_type e;
      nr = clamp_dim(shadow_cfg.rows_a);
      nk = clamp_dim(shadow_cfg.cols_a);
      nc = (shadow_cfg.mode == MODE_MUL) ? clamp_dim(shadow_cfg.cols_b) : nk;
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            case (shadow_cfg.mode)
               MODE_ADD: acc = mat_a[i*GRID+j] + mat_b[i*GRID+j];
               MODE_SUB: acc = mat_a[i*GRID+j] - mat_b[i*GRID+j];
               MODE_MUL: begin
                  acc = '0;
                  for (int k = 0; k < nk; k++)
                     acc = acc + mat_a[i*GRID+k] * mat_b[k*GRID+j];
               end
               default: acc = mat_a[i*GRID+j] * 32'(shadow_cfg.scale_factor);
            endcase
            e.result_value = acc;
            e.result_row = 3'(i);
            e.result_col = 3'(j);
            e.last = (i == nr - 1) && (j == nc - 1);
            expected_elems.push_back(e);
         end
      end
   endfunction

   function automatic void absorb_req_beat(smae_req_type r);
      case (r.op)
         OP_LOAD_A: begin
            mat_a[{r.row, r.col}] = r.value;
            load_beats++;
         end
         OP_LOAD_B: begin
            mat_b[{r.row, r.col}] = r.value;
            load_beats++;
         end
         OP_START: begin
            expand_result();
            start_beats++;
         end
         default: ;
      endcase
   endfunction

   function automatic void push_beat(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                                     logic [31:0] value);
      smae_req_type r;
      r.op = op;
      r.row = row;
      r.col = col;
      r.value = value;
      if (op == OP_LOAD_A) filled_a[{row, col}] = 1'b1;
      if (op == OP_LOAD_B) filled_b[{row, col}] = 1'b1;
      pend_reqs.push_back(r);
      gen_items++;
   endfunction

   // load every entry the start will read that has not been written yet, then push the start
   function automatic void push_start();
      int nr;
      int nk;
      int nc;
      nr = clamp_dim(shadow_cfg.rows_a);
      nk = clamp_dim(shadow_cfg.cols_a);
      nc = (shadow_cfg.mode == MODE_MUL) ? clamp_dim(shadow_cfg.cols_b) : nk;
      for (int i = 0; i < GRID; i++) begin
         for (int j = 0; j < GRID; j++) begin
            if (shadow_cfg.mode == MODE_MUL) begin
               if (i < nr && j < nk && !filled_a[i*GRID+j])
                  push_beat(OP_LOAD_A, 3'(i), 3'(j), $urandom());
               if (i < nk && j < nc && !filled_b[i*GRID+j])
                  push_beat(OP_LOAD_B, 3'(i), 3'(j), $urandom());
            end else if (i < nr && j < nk) begin
               if (!filled_a[i*GRID+j]) push_beat(OP_LOAD_A, 3'(i), 3'(j), $urandom());
               if (!filled_b[i*GRID+j]) push_beat(OP_LOAD_B, 3'(i), 3'(j), $urandom());
            end
         end
      end
      push_beat(OP_START, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom());
   endfunction

   // well-formed run: loads inside the active shape, then one or two starts
   function automatic void push_shaped_run();
      int nr;
      int nk;
      int nc;
      int n;
      nr = clamp_dim(shadow_cfg.rows_a);
      nk = clamp_dim(shadow_cfg.cols_a);
      nc = (shadow_cfg.mode == MODE_MUL) ? clamp_dim(shadow_cfg.cols_b) : nk;
      n = $urandom_range(1, 8);
      for (int m = 0; m < n; m++) begin
         if ($urandom_range(0, 1))
            push_beat(OP_LOAD_A, 3'($urandom_range(0, nr - 1)), 3'($urandom_range(0, nk - 1)),
                      $urandom());
         else if (shadow_cfg.mode == MODE_MUL)
            push_beat(OP_LOAD_B, 3'($urandom_range(0, nk - 1)), 3'($urandom_range(0, nc - 1)),
                      $urandom());
         else
            push_beat(OP_LOAD_B, 3'($urandom_range(0, nr - 1)), 3'($urandom_range(0, nk - 1)),
                      $urandom());
      end
      push_start();
      if ($urandom_range(0, 3) == 0) push_start();
   endfunction

   function automatic void push_noise();
      int n;
      logic [1:0] op;
      n = $urandom_range(1, 6);
      for (int m = 0; m < n; m++) begin
         op = 2'($urandom_range(0, 3));
         if (op == OP_START)
            push_start();
         else
            push_beat(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom());
      end
   endfunction

   function automatic logic [31:0] dim_word();
      int pick;
      logic [3:0] d;
      pick = $urandom_range(0, 19);
      if (pick == 0) d = 4'd0;
      else if (pick == 1) d = 4'd8;
      else if (pick == 2) d = 4'($urandom_range(9, 15));
      else d = 4'($urandom_range(1, 4));
      return ($urandom() & 32'hFFFF_FFF0) | 32'(d);
   endfunction

   function automatic logic [31:0] scale_word();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'($urandom_range(0, 7));
         default: return $urandom();
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      shadow_reg_write(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_engine();
      while (taken_items != gen_items || expected_elems.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_req_beat(req_data);
            taken_items++;
         end
         if (!req_valid || req_ready) begin
            if (pend_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data <= pend_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      smae_rsp_type want;
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_elems.size() == 0) begin
            $error("result beat with nothing expected: row %0d col %0d value %0d",
                   rsp_data.result_row, rsp_data.result_col, rsp_data.result_value);
            fail_count++;
         end else begin
            want = expected_elems.pop_front();
            checked_elems++;
            if (rsp_data.result_value !== want.result_value) begin
               $error("result_value: expected %0d, got %0d",
                      want.result_value, rsp_data.result_value);
               fail_count++;
            end
            if (rsp_data.result_row !== want.result_row) begin
               $error("result_row: expected %0d, got %0d", want.result_row, rsp_data.result_row);
               fail_count++;
            end
            if (rsp_data.result_col !== want.result_col) begin
               $error("result_col: expected %0d, got %0d", want.result_col, rsp_data.result_col);
               fail_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      foreach (mat_a[i]) begin
         mat_a[i] = '0;
         mat_b[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: wrap at both ends, every mode, unused op and unused register
      write_reg(CSR_ROWS_A, 32'd1);
      write_reg(CSR_COLS_A, 32'd2);
      write_reg(CSR_COLS_B, 32'd2);
      write_reg(CSR_MODE, 32'(MODE_ADD));
      push_beat(OP_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
      push_beat(OP_LOAD_A, 3'd0, 3'd1, 32'h8000_0000);
      push_beat(OP_LOAD_B, 3'd0, 3'd0, 32'd1);
      push_beat(OP_LOAD_B, 3'd0, 3'd1, 32'hFFFF_FFFF);
      push_beat(OP_LOAD_A, 3'd7, 3'd7, 32'd0);
      push_beat(OP_LOAD_B, 3'd7, 3'd7, 32'hFFFF_FFFF);
      push_beat(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
      push_start();
      drain_engine();
      write_reg(CSR_MODE, 32'(MODE_SUB));
      push_start();
      drain_engine();
      write_reg(CSR_MODE, 32'(MODE_MUL));
      push_beat(OP_LOAD_B, 3'd1, 3'd0, 32'h8000_0000);
      push_beat(OP_LOAD_B, 3'd1, 3'd1, 32'd2);
      push_start();
      drain_engine();
      write_reg(CSR_SCALE, 32'h8000_0000);
      write_reg(CSR_MODE, 32'(MODE_SCALE));
      push_start();
      drain_engine();
      write_reg(CSR_SCALE, 32'h7FFF_FFFF);
      write_reg(CSR_UNUSED, $urandom());
      push_beat(OP_UNUSED, 3'd0, 3'd0, 32'd0);
      push_start();
      drain_engine();
      settings_run = 5;

      // random phases, each under a fresh register setting
      while (gen_items < 500) begin
         if (gen_items < 170) begin
            send_idle_pct = 26;
            recv_idle_pct = 86;
         end else if (gen_items < 340) begin
            send_idle_pct = 86;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_reg(CSR_MODE, ($urandom() & 32'hFFFF_FFFC) | 32'($urandom_range(0, 3)));
         if ($urandom_range(0, 1)) write_reg(CSR_ROWS_A, dim_word());
         if ($urandom_range(0, 1)) write_reg(CSR_COLS_A, dim_word());
         if ($urandom_range(0, 1)) write_reg(CSR_COLS_B, dim_word());
         if ($urandom_range(0, 2) == 0) write_reg(CSR_SCALE, scale_word());
         if ($urandom_range(0, 15) == 0)
            write_reg(CSR_IDX_W'(5 + $urandom_range(0, 2)), $urandom());
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 4) == 0) push_noise();
            else push_shaped_run();
         end
         drain_engine();
         settings_run++;
      end

      $display("Covered %0d load beats and %0d start beats, %0d result elements checked",
               load_beats, start_beats, checked_elems);
      $display("Ran %0d register settings, with clamped sizes and both idle mixes",
               settings_run);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
